/* sv/ast_pkg.sv */
// Package for the adaptive staircase tracker: widths, reset values,
// configuration register indexes and the move-direction type.
// No dependencies.
package ast_pkg;

	localparam int FRAC_BITS      = 4;
	localparam int LEVEL_W        = 16;
	localparam int STEP_W         = 12;
	localparam int REV_W          = 4;
	localparam int TRIAL_W        = 8;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int DEF_AVG_WINDOW = 6;

	// reset values of the configuration registers
	localparam logic signed [LEVEL_W-1:0] RST_START_LEVEL = '0;
	localparam logic signed [LEVEL_W-1:0] RST_LEVEL_MIN   = {1'b1, {(LEVEL_W-1){1'b0}}};
	localparam logic signed [LEVEL_W-1:0] RST_LEVEL_MAX   = {1'b0, {(LEVEL_W-1){1'b1}}};
	localparam logic [STEP_W-1:0]         RST_INIT_STEP   = STEP_W'(6 << FRAC_BITS);
	localparam logic [STEP_W-1:0]         RST_MIN_STEP    = STEP_W'(1 << FRAC_BITS);
	localparam logic [REV_W-1:0]          RST_MAX_REV     = REV_W'(9);
	localparam logic [TRIAL_W-1:0]        RST_MAX_TRIALS  = TRIAL_W'(120);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_LEVEL  = 3'd0,
		CFG_LEVEL_MIN    = 3'd1,
		CFG_LEVEL_MAX    = 3'd2,
		CFG_INITIAL_STEP = 3'd3,
		CFG_MIN_STEP     = 3'd4,
		CFG_MAX_REV      = 3'd5,
		CFG_MAX_TRIALS   = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_UP   = 2'd2
	} dir_t;

endpackage

/* sv/ast_mean.sv */
// Window mean: signed sum divided by the window length, truncated toward zero.
// Reciprocal multiply on the magnitude, then the sign is put back.
// Depends on ast_pkg.
module ast_mean #(
	parameter int AVG_WINDOW = ast_pkg::DEF_AVG_WINDOW
) (
	input  logic signed [ast_pkg::LEVEL_W+$clog2(AVG_WINDOW)-1:0] sum,
	output logic signed [ast_pkg::LEVEL_W-1:0]                    mean
);
	import ast_pkg::*;

	localparam int SUM_W   = LEVEL_W + $clog2(AVG_WINDOW);
	// K leaves the reciprocal error well under 1/AVG_WINDOW over the full sum range
	localparam int K       = SUM_W + 4;
	localparam int RECIP_W = K + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << K) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));
	localparam int PROD_W  = SUM_W + RECIP_W;

	logic              neg;
	logic [SUM_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  quot;

	assign neg  = sum[SUM_W-1];
	assign mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
	assign prod = PROD_W'(mag) * PROD_W'(RECIP);
	assign quot = prod[K +: SUM_W];
	assign mean = neg ? LEVEL_W'(-quot) : LEVEL_W'(quot);

endmodule

/* sv/adaptive_staircase_tracker.sv */
// Top level of the 2-down/1-up adaptive staircase tracker.
// Holds configuration, tracker state, reversal window and a two-stage output pipe.
// Depends on ast_pkg and ast_mean.
//
//   channel   signals                                  direction  transfer when
//   item      item_valid, item_stall, answer_correct    in         valid & !stall
//   result    result_valid, result_stall, level ...     out        valid & !stall
//   config    cfg_we, cfg_index, cfg_data               in         cfg_we
//
// One answer per cycle while the item side is not stalled. Tracker state updates in
// the cycle an answer is taken; stage 1 registers the status and window sum, stage 2
// adds the mean (reciprocal multiply) and drives the result outputs.
// Reset clears tracker state and loads the default configuration; the window
// entries hold nothing until written. A stalled result holds stage 2, and the
// item side stalls only when both stages hold results.
module adaptive_staircase_tracker #(
	parameter int AVG_WINDOW = ast_pkg::DEF_AVG_WINDOW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// trial outcomes
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                answer_correct,
	// per-trial status
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [ast_pkg::LEVEL_W-1:0]  level,
	output logic                                finished,
	output logic                                estimate_valid,
	output logic signed [ast_pkg::LEVEL_W-1:0]  threshold,
	output logic [ast_pkg::REV_W-1:0]           reversals_seen,
	output logic [ast_pkg::TRIAL_W-1:0]         trials_seen,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [ast_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ast_pkg::CFG_W-1:0]           cfg_data
);
	import ast_pkg::*;

	localparam int SUM_W  = LEVEL_W + $clog2(AVG_WINDOW);
	localparam int SLOT_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
	localparam logic [REV_W-1:0]  WIN_LEN   = REV_W'(AVG_WINDOW);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_WINDOW - 1);

	// clamp: lower bound first, upper bound second (upper wins on crossed bounds)
	function automatic logic signed [LEVEL_W-1:0] clamp_lvl(
		input logic signed [LEVEL_W:0]   v,
		input logic signed [LEVEL_W-1:0] lo,
		input logic signed [LEVEL_W-1:0] hi
	);
		logic signed [LEVEL_W:0] t;
		t = v;
		if (t < (LEVEL_W+1)'(lo)) t = (LEVEL_W+1)'(lo);
		if (t > (LEVEL_W+1)'(hi)) t = (LEVEL_W+1)'(hi);
		return LEVEL_W'(t);
	endfunction

	// ---------------- configuration registers ----------------
	logic signed [LEVEL_W-1:0] level_min_q, level_max_q;
	logic [STEP_W-1:0]         min_step_q;
	logic [REV_W-1:0]          max_rev_q;
	logic [TRIAL_W-1:0]        max_trials_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_min_q   <= RST_LEVEL_MIN;
			level_max_q   <= RST_LEVEL_MAX;
			min_step_q    <= RST_MIN_STEP;
			max_rev_q     <= RST_MAX_REV;
			max_trials_q  <= RST_MAX_TRIALS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				// start level and first step only act before the first trial,
				// where they load the tracker state directly
				CFG_START_LEVEL, CFG_INITIAL_STEP: ;
				CFG_LEVEL_MIN:    level_min_q   <= LEVEL_W'(cfg_data);
				CFG_LEVEL_MAX:    level_max_q   <= LEVEL_W'(cfg_data);
				CFG_MIN_STEP:     min_step_q    <= cfg_data[STEP_W-1:0];
				CFG_MAX_REV:      max_rev_q     <= cfg_data[REV_W-1:0];
				CFG_MAX_TRIALS:   max_trials_q  <= cfg_data[TRIAL_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	logic v_s1, v_s2;
	logic adv1, adv2, take;

	assign adv2       = !v_s2 || !result_stall;
	assign adv1       = !v_s1 || adv2;
	assign item_stall = !adv1;
	assign take       = item_valid && adv1;

	// ---------------- tracker state ----------------
	logic signed [LEVEL_W-1:0] cur_q;
	logic [STEP_W-1:0]         step_q;
	logic                      run_q;
	dir_t                      last_dir_q;
	logic [REV_W-1:0]          rev_q;
	logic [TRIAL_W-1:0]        trial_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      done_q;
	logic [SLOT_W-1:0]         slot_q;
	logic signed [LEVEL_W-1:0] win_q [AVG_WINDOW];

	// next-state logic for one answer
	logic                      stopped;    // limits already met: answer ignored
	logic signed [LEVEL_W-1:0] lvl;        // clamped current level
	dir_t                      dir;
	logic                      run_n;
	logic                      reversal;
	logic [STEP_W-1:0]         step_half, step_n;
	logic signed [LEVEL_W:0]   moved;
	logic signed [LEVEL_W-1:0] cur_n;
	logic [REV_W-1:0]          rev_n;
	logic [TRIAL_W-1:0]        trial_n;
	logic signed [SUM_W-1:0]   sum_n;
	logic signed [LEVEL_W-1:0] old_entry;
	logic                      done_n;

	always_comb begin
		stopped   = done_q || (rev_q >= max_rev_q) || (trial_q >= max_trials_q);
		lvl       = clamp_lvl((LEVEL_W+1)'(cur_q), level_min_q, level_max_q);

		// 2-down/1-up: second correct in a row moves down, any wrong moves up
		dir   = DIR_NONE;
		run_n = 1'b0;
		if (answer_correct) begin
			if (run_q) dir = DIR_DOWN;
			else run_n = 1'b1;
		end else begin
			dir = DIR_UP;
		end

		reversal  = (dir != DIR_NONE) && (last_dir_q != DIR_NONE) && (dir != last_dir_q);
		step_half = step_q >> 1;
		step_n    = step_q;
		if (reversal) step_n = (step_half < min_step_q) ? min_step_q : step_half;

		moved = (dir == DIR_UP) ? (LEVEL_W+1)'(lvl) + (LEVEL_W+1)'(step_n)
		                        : (LEVEL_W+1)'(lvl) - (LEVEL_W+1)'(step_n);
		cur_n = (dir != DIR_NONE) ? clamp_lvl(moved, level_min_q, level_max_q) : lvl;

		// running window sum; the slot's old entry counts only once the window is full
		old_entry = win_q[slot_q];
		sum_n     = sum_q;
		rev_n     = rev_q;
		if (reversal) begin
			sum_n = sum_q + SUM_W'(lvl)
			        - ((rev_q >= WIN_LEN) ? SUM_W'(old_entry) : SUM_W'(0));
			rev_n = rev_q + REV_W'(1);
		end
		trial_n = trial_q + TRIAL_W'(1);
		done_n  = (rev_n >= max_rev_q) || (trial_n >= max_trials_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= RST_START_LEVEL;
			step_q     <= RST_INIT_STEP;
			run_q      <= 1'b0;
			last_dir_q <= DIR_NONE;
			rev_q      <= '0;
			trial_q    <= '0;
			sum_q      <= '0;
			done_q     <= 1'b0;
			slot_q     <= '0;
		end else if (take) begin
			if (stopped) begin
				done_q <= 1'b1;
			end else begin
				cur_q   <= cur_n;
				step_q  <= step_n;
				run_q   <= run_n;
				rev_q   <= rev_n;
				trial_q <= trial_n;
				sum_q   <= sum_n;
				done_q  <= done_n;
				if (dir != DIR_NONE) last_dir_q <= dir;
				if (reversal) slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
			end
		end else if (cfg_we && trial_q == '0) begin
			// before the first trial, start values follow the config
			if (cfg_index == CFG_START_LEVEL)  cur_q  <= LEVEL_W'(cfg_data);
			if (cfg_index == CFG_INITIAL_STEP) step_q <= cfg_data[STEP_W-1:0];
		end
	end

	// reversal levels, one slot per reversal in rotation
	always_ff @(posedge clk) begin
		if (take && !stopped && reversal) win_q[slot_q] <= lvl;
	end

	// ---------------- stage 1: status ----------------
	logic signed [LEVEL_W-1:0] level_s1;
	logic                      fin_s1, est_s1;
	logic signed [SUM_W-1:0]   sum_s1;
	logic [REV_W-1:0]          rev_s1;
	logic [TRIAL_W-1:0]        trial_s1;

	logic                      fin_x;
	logic [REV_W-1:0]          rev_x;

	assign fin_x = stopped ? 1'b1 : done_n;
	assign rev_x = stopped ? rev_q : rev_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			level_s1 <= stopped ? lvl : cur_n;
			fin_s1   <= fin_x;
			est_s1   <= fin_x && (rev_x >= WIN_LEN);
			sum_s1   <= stopped ? sum_q : sum_n;
			rev_s1   <= rev_x;
			trial_s1 <= stopped ? trial_q : trial_n;
		end
	end

	// ---------------- stage 2: mean of the window ----------------
	logic signed [LEVEL_W-1:0] mean;

	ast_mean #(
		.AVG_WINDOW(AVG_WINDOW)
	) u_mean (
		.sum  (sum_s1),
		.mean (mean)
	);

	logic signed [LEVEL_W-1:0] level_s2, thr_s2;
	logic                      fin_s2, est_s2;
	logic [REV_W-1:0]          rev_s2;
	logic [TRIAL_W-1:0]        trial_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			level_s2 <= level_s1;
			fin_s2   <= fin_s1;
			est_s2   <= est_s1;
			thr_s2   <= est_s1 ? mean : '0;
			rev_s2   <= rev_s1;
			trial_s2 <= trial_s1;
		end
	end

	assign result_valid   = v_s2;
	assign level          = level_s2;
	assign finished       = fin_s2;
	assign estimate_valid = est_s2;
	assign threshold      = thr_s2;
	assign reversals_seen = rev_s2;
	assign trials_seen    = trial_s2;

endmodule
